FILE: rtl/vhc_pkg.sv
// ----------------------------------------------------------------------------
// Vector to HSL colour package
// Shared widths, the arctangent table and the record that moves along the
// chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package vhc_pkg;

  // Input component width (signed Q4.12).
  localparam int IN_W = 16;

  // Number of CORDIC micro-rotations (8..24).
  localparam int ANGLE_STAGES = 16;

  // Fraction bits of the lightness (8..32).
  localparam int COMPONENT_WIDTH = 16;

  // Extra low bits carried through the rotations.
  localparam int GUARD_BITS = 8;

  // Rotation datapath width: input, guard bits, gain and magnitude growth.
  localparam int CORDIC_W = IN_W + GUARD_BITS + 4;

  // Angle accumulator, units of 2^-32 turn.
  localparam int ANG_W = 32;

  // Square root: one result bit per cell.
  localparam int SQRT_STEPS = COMPONENT_WIDTH - 1;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int REM_W      = SQRT_STEPS + 3;

  // The chain is long enough for both the rotations and the root.
  localparam int NUM_CELLS = (ANGLE_STAGES > SQRT_STEPS) ? ANGLE_STAGES : SQRT_STEPS;
  localparam int SHIFT_W   = $clog2(NUM_CELLS);

  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = NUM_CELLS + 6;

  // Hue constants in turns.
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [15:0]      THIRD_Q16 = 16'd21845;

  // atan(2^-i) in units of 2^-32 turn.
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
  localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Table lookup that is safe for any cell position.
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned idx);
    logic [ANG_W-1:0] val;
    val = '0;
    if (idx < ATAN_ENTRIES) begin
      val = ATAN_TURNS[idx[ATAN_IDX_W-1:0]];
    end
    return val;
  endfunction

  // Per-cell settings, fixed at elaboration.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [ANG_W-1:0]   atan;
    logic               cordic_en;
    logic               sqrt_en;
  } vhc_ctl_t;

  // Record handed from cell to cell.
  typedef struct packed {
    logic                       valid;
    logic                       sat;
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic [ANG_W-1:0]           ang;
    logic [RAD_W-1:0]           rad;
    logic [REM_W-1:0]           rem;
    logic [SQRT_STEPS-1:0]      root;
  } vhc_cell_t;

endpackage

`default_nettype wire

FILE: rtl/vhc_front.sv
// ----------------------------------------------------------------------------
// Vector to HSL colour front end
// Squares the components, checks the lightness limit, scales the radicand
// and rotates the vector into the right half plane for the CORDIC chain.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_front
  import vhc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic signed [IN_W-1:0] vec_x_i,
  input  logic signed [IN_W-1:0] vec_y_i,
  output vhc_cell_t              cell_o
);

  logic                       v1_q;
  logic signed [2*IN_W-1:0]   xx_q, yy_q;
  logic signed [CORDIC_W-1:0] cx1_q, cy1_q;
  logic [ANG_W-1:0]           ang1_q;

  logic signed [CORDIC_W-1:0] cx_d, cy_d;
  logic [ANG_W-1:0]           ang_d;

  vhc_cell_t cell_d, cell_q;

  // Start vector is (-y, x); a point in the left half plane is turned by half a turn.
  always_comb begin
    logic signed [CORDIC_W-1:0] vx_ext;
    logic signed [CORDIC_W-1:0] vy_ext;
    logic signed [CORDIC_W-1:0] cx0;
    logic signed [CORDIC_W-1:0] cy0;
    vx_ext = CORDIC_W'(vec_x_i);
    vy_ext = CORDIC_W'(vec_y_i);
    cx0    = -(vy_ext <<< GUARD_BITS);
    cy0    = vx_ext <<< GUARD_BITS;
    if (cx0[CORDIC_W-1]) begin
      cx_d  = -cx0;
      cy_d  = -cy0;
      ang_d = HALF_TURN;
    end else begin
      cx_d  = cx0;
      cy_d  = cy0;
      ang_d = '0;
    end
  end

  // First stage: squares and the pre-rotated vector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q   <= vec_x_i * vec_x_i;
    yy_q   <= vec_y_i * vec_y_i;
    cx1_q  <= cx_d;
    cy1_q  <= cy_d;
    ang1_q <= ang_d;
  end

  // Second stage: sum of squares, limit at a magnitude of one half, radicand.
  always_comb begin
    logic [2*IN_W-1:0]    sum;
    logic [RAD_W+21:0]    wide;
    sum  = $unsigned(xx_q) + $unsigned(yy_q);
    wide = {sum[21:0], {RAD_W{1'b0}}};
    cell_d       = '0;
    cell_d.valid = v1_q;
    cell_d.sat   = |sum[2*IN_W-1:22];
    cell_d.cx    = cx1_q;
    cell_d.cy    = cy1_q;
    cell_d.ang   = ang1_q;
    cell_d.rad   = wide[RAD_W+21:22];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: rtl/vhc_cell.sv
// ----------------------------------------------------------------------------
// Vector to HSL colour chain cell
// One CORDIC micro-rotation and one square root digit, registered and
// handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_cell
  import vhc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vhc_ctl_t  ctl_i,
  input  vhc_cell_t cell_i,
  output vhc_cell_t cell_o
);

  vhc_cell_t cell_d, cell_q;

  always_comb begin
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           trial;
    logic                       take;
    cx     = cell_i.cx;
    cy     = cell_i.cy;
    dx     = cy >>> ctl_i.shift;
    dy     = cx >>> ctl_i.shift;
    rem_sh = {cell_i.rem[REM_W-3:0], cell_i.rad[RAD_W-1 -: 2]};
    trial  = REM_W'({cell_i.root, 2'b01});
    take   = (rem_sh >= trial);
    cell_d = cell_i;

    // Rotate toward the x axis and track the angle turned.
    if (ctl_i.cordic_en) begin
      if (!cy[CORDIC_W-1]) begin
        cell_d.cx  = cx + dx;
        cell_d.cy  = cy - dy;
        cell_d.ang = cell_i.ang + ctl_i.atan;
      end else begin
        cell_d.cx  = cx - dx;
        cell_d.cy  = cy + dy;
        cell_d.ang = cell_i.ang - ctl_i.atan;
      end
    end

    // Restoring square root: bring down two radicand bits, settle one root bit.
    if (ctl_i.sqrt_en) begin
      cell_d.rad  = {cell_i.rad[RAD_W-3:0], 2'b00};
      cell_d.rem  = take ? (rem_sh - trial) : rem_sh;
      cell_d.root = {cell_i.root[SQRT_STEPS-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: rtl/vhc_back.sv
// ----------------------------------------------------------------------------
// Vector to HSL colour back end
// Turns angle and root into hue and lightness, applies the hue ramp per
// channel and scales each channel to 0..255 with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module vhc_back
  import vhc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vhc_cell_t cell_i,
  output logic      done_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  localparam int Q_W = COMPONENT_WIDTH + 1;
  localparam int M_W = Q_W + 17;
  localparam int P_W = M_W + 8;
  localparam int SH  = COMPONENT_WIDTH + 16;

  // Piecewise HSL ramp in Q1.16: 6t, 1, 4 - 6t, 0.
  function automatic logic [16:0] ramp_q16(input logic [15:0] t);
    logic [18:0] t6;
    logic [17:0] t3;
    logic [18:0] fall;
    logic [16:0] val;
    t6   = {t, 2'b00} + {1'b0, t, 1'b0};
    t3   = {t, 1'b0} + {2'b00, t};
    fall = 19'd262144 - t6;
    if (t6 < 19'd65536) begin
      val = t6[16:0];
    end else if (!t[15]) begin
      val = 17'h10000;
    end else if (t3 < 18'd131072) begin
      val = fall[16:0];
    end else begin
      val = '0;
    end
    return val;
  endfunction

  logic             b1_v_q, b2_v_q, b3_v_q, done_q;
  logic [Q_W-1:0]   q1_q, q2_q;
  logic [15:0]      h1_q;
  logic [16:0]      ramp_q [3];
  logic [M_W-1:0]   m_q [3];
  logic [7:0]       chan_q [3];
  logic [7:0]       chan_d [3];
  logic [ANG_W-1:0] hue32;
  logic [15:0]      t_d [3];

  // Hue is half a turn minus the angle, rounded to Q0.16.
  assign hue32 = (HALF_TURN + 32'h0000_8000) - cell_i.ang;

  // Channel offsets of +1/3, 0 and -1/3 turn, wrapping.
  assign t_d[0] = h1_q + THIRD_Q16;
  assign t_d[1] = h1_q;
  assign t_d[2] = h1_q - THIRD_Q16;

  // Final scaling: m * 255, rounded half up.
  always_comb begin
    logic [P_W-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod      = ({m_q[c], 8'h00} - P_W'(m_q[c])) + (P_W'(1) << (SH - 1));
      chan_d[c] = prod[SH+7:SH];
    end
  end

  // Valid bits through the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      b1_v_q <= cell_i.valid;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      done_q <= b3_v_q;
    end
  end

  // Datapath stages: hue and q, ramps, products, channels.
  always_ff @(posedge clk_i) begin
    q1_q <= cell_i.sat ? {1'b1, {COMPONENT_WIDTH{1'b0}}} : {1'b0, cell_i.root, 1'b0};
    h1_q <= hue32[31:16];
    q2_q <= q1_q;
    for (int c = 0; c < 3; c++) begin
      ramp_q[c] <= ramp_q16(t_d[c]);
      m_q[c]    <= M_W'(q2_q) * M_W'(ramp_q[c]);
      chan_q[c] <= chan_d[c];
    end
  end

  assign done_o  = done_q;
  assign red_o   = chan_q[0];
  assign green_o = chan_q[1];
  assign blue_o  = chan_q[2];

endmodule

`default_nettype wire

FILE: rtl/vector_to_hsl_colour.sv
// ----------------------------------------------------------------------------
// Vector to HSL colour: done_o marks the result of each accepted start.
// One vector per cycle; busy_o stays low and results cannot be stalled.
// Each vector passes the front end, the chain of rotation and root cells and the back end.
// Reset clears all valid bits; no transfer is in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_to_hsl_colour
  import vhc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [IN_W-1:0] vec_x_i,
  input  logic signed [IN_W-1:0] vec_y_i,
  output logic                   done_o,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);

  logic      accept;
  vhc_cell_t chain [NUM_CELLS+1];

  // Fully pipelined: a new transfer is taken in every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  vhc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .vec_x_i  (vec_x_i),
    .vec_y_i  (vec_y_i),
    .cell_o   (chain[0])
  );

  // Chain of cells, each with its own shift, arctangent and enables.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    vhc_ctl_t ctl;
    assign ctl.shift     = SHIFT_W'(g);
    assign ctl.atan      = atan_turn(g);
    assign ctl.cordic_en = (g < ANGLE_STAGES);
    assign ctl.sqrt_en   = (g < SQRT_STEPS);

    vhc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  vhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (chain[NUM_CELLS]),
    .done_o  (done_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

`ifndef ASSERT_OFF
  // Every accepted transfer produces a result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result strobe missing after accepted transfer");

  // A result never appears without a matching accepted transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without accepted transfer");

  // A zero vector has zero lightness and gives black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(accept && (vec_x_i == '0) && (vec_y_i == '0), LATENCY))
      |-> (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0))
    else $error("zero vector did not give black");
`endif

endmodule

`default_nettype wire
